@@ sv/rtti_pkg.sv @@
// Shared types, constants and character helpers for the radix text-to-integer core.
// No dependencies; design files use scoped names into it, the testbench imports it.
`timescale 1ns / 1ps
`default_nettype none

package rtti_pkg;

  localparam int VALUE_BITS_DEF    = 32;
  localparam int POSITION_BITS_DEF = 16;

  localparam int CH_W    = 8;
  localparam int RADIX_W = 6;
  localparam int VALUE_W = 33;
  localparam int END_W   = 16;
  localparam int DIGIT_W = 7;

  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_HT    = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CH_W-1:0] CH_UC_X  = 8'h58;
  localparam logic [CH_W-1:0] CH_UC_Z  = 8'h5A;
  localparam logic [CH_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CH_W-1:0] CH_LC_X  = 8'h78;
  localparam logic [CH_W-1:0] CH_LC_Z  = 8'h7A;

  localparam logic [RADIX_W-1:0] BASE_DETECT = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
  localparam logic [RADIX_W-1:0] BASE_MAX    = 6'd36;

  // digit value of a non-alphanumeric character; above any legal base
  localparam logic [DIGIT_W-1:0] NOT_DIGIT = 7'd99;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACE,
    PH_SIGN,
    PH_ZERO,
    PH_PREFIX,
    PH_DIGITS
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic               negative;
    logic [RADIX_W-1:0] base;
    logic               overflowed;
    logic               seen_digit;
  } ctl_t;

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_HT && c <= CH_CR);
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_value(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] t;
    t = NOT_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) t = c - CH_ZERO;
    else if (c >= CH_UC_A && c <= CH_UC_Z) t = c - CH_UC_A + 8'd10;
    else if (c >= CH_LC_A && c <= CH_LC_Z) t = c - CH_LC_A + 8'd10;
    return t[DIGIT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/rtti_in_if.sv @@
// Character channel: valid/ready handshake with one character per beat.
// Depends on rtti_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rtti_in_if;
  logic                        valid;
  logic                        ready;
  logic [rtti_pkg::CH_W-1:0]    ch;
  logic                        start_req;
  logic [rtti_pkg::RADIX_W-1:0] radix;

  modport source (output valid, output ch, output start_req, output radix, input ready);
  modport sink   (input valid, input ch, input start_req, input radix, output ready);
endinterface

`default_nettype wire

@@ sv/rtti_out_if.sv @@
// Result channel: valid/ready handshake with one conversion result per beat.
// Depends on rtti_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rtti_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rtti_pkg::VALUE_W-1:0] value;
  logic                               range_error;
  logic [rtti_pkg::END_W-1:0]          end_offset;

  modport source (output valid, output value, output range_error, output end_offset,
                  input ready);
  modport sink   (input valid, input value, input range_error, input end_offset,
                  output ready);
endinterface

`default_nettype wire

@@ sv/radix_text_to_integer_core.sv @@
// Streaming text-to-integer converter (strtol/strtoul style), top level.
// Depends on rtti_pkg, rtti_in_if, rtti_out_if, rtti_step and rtti_emit.
//
// Usage:
//   din  carries one character per beat. A beat with start_req high begins a new
//        string and supplies its radix (0 detects, 2..36 fixed). Beats without
//        start_req while no string is open are dropped.
//   dout carries one result per finished string: value, range_error, end_offset.
//        A string finishes on the first non-digit past blanks, sign and prefix;
//        an illegal radix finishes it on the start beat with a no-conversion result.
//   cfg_we/cfg_wdata write unsigned_mode; write it only while no string is open.
// Timing:
//   One character per cycle sustained while dout is not stalled. A beat is held in
//   the input register, then the parse step updates the state and loads the result
//   register, which raises dout.valid for the terminating character.
//   The single multiply-add with its limit compare sets the cycle time.
// Reset (rst, synchronous) drops both registers, clears the parser state to idle
// and sets signed mode. When dout stalls with a result held, the character in the
// input register waits and din.ready falls until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module radix_text_to_integer_core #(
  parameter int VALUE_BITS    = rtti_pkg::VALUE_BITS_DEF,
  parameter int POSITION_BITS = rtti_pkg::POSITION_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  rtti_in_if.sink   din,
  rtti_out_if.source dout,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);

  // input register
  logic                        iv;
  logic [rtti_pkg::CH_W-1:0]    ch;
  logic                        start_req;
  logic [rtti_pkg::RADIX_W-1:0] radix;

  // parser state
  logic                        unsigned_mode;
  rtti_pkg::ctl_t              ctl;
  logic [VALUE_BITS-1:0]       acc;
  logic [POSITION_BITS-1:0]    pos;

  // result register
  logic                               ov;
  logic signed [rtti_pkg::VALUE_W-1:0] value;
  logic                               range_error;
  logic [rtti_pkg::END_W-1:0]          end_offset;

  rtti_pkg::ctl_t                     ctl_next;
  logic [VALUE_BITS-1:0]              acc_next;
  logic [POSITION_BITS-1:0]           pos_next;
  logic [POSITION_BITS-1:0]           emit_pos;
  logic                               emit;
  logic signed [rtti_pkg::VALUE_W-1:0] value_next;
  logic                               range_error_next;
  logic [rtti_pkg::END_W-1:0]          end_offset_next;
  logic                               go;

  assign go        = iv && (!ov || dout.ready);
  assign din.ready = !iv || go;

  rtti_step #(
    .VALUE_BITS   (VALUE_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .ch           (ch),
    .start_req    (start_req),
    .radix        (radix),
    .unsigned_mode(unsigned_mode),
    .ctl          (ctl),
    .acc          (acc),
    .pos          (pos),
    .ctl_next     (ctl_next),
    .acc_next     (acc_next),
    .pos_next     (pos_next),
    .emit_pos     (emit_pos),
    .emit         (emit)
  );

  // formats from the state as it stands when the terminating character is seen
  rtti_emit #(
    .VALUE_BITS   (VALUE_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_emit (
    .unsigned_mode(unsigned_mode),
    .ctl          (ctl_next),
    .acc          (acc_next),
    .pos          (emit_pos),
    .value        (value_next),
    .range_error  (range_error_next),
    .end_offset   (end_offset_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      iv            <= 1'b0;
      ov            <= 1'b0;
      unsigned_mode <= 1'b0;
      ctl           <= '{phase: rtti_pkg::PH_IDLE, negative: 1'b0, base: '0,
                         overflowed: 1'b0, seen_digit: 1'b0};
      acc           <= '0;
      pos           <= '0;
    end else begin
      if (cfg_we) unsigned_mode <= cfg_wdata;
      if (din.ready) iv <= din.valid;
      if (go) begin
        ctl <= ctl_next;
        acc <= acc_next;
        pos <= pos_next;
      end
      if (go && emit) ov <= 1'b1;
      else if (dout.ready) ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (din.ready && din.valid) begin
      ch        <= din.ch;
      start_req <= din.start_req;
      radix     <= din.radix;
    end
    if (go && emit) begin
      value       <= value_next;
      range_error <= range_error_next;
      end_offset  <= end_offset_next;
    end
  end

  assign dout.valid       = ov;
  assign dout.value       = value;
  assign dout.range_error = range_error;
  assign dout.end_offset  = end_offset;

endmodule

`default_nettype wire

@@ sv/rtti_step.sv @@
// Per-character parser step: next phase, base, accumulator and position.
// Combinational; one multiply-add and limit compare. Depends on rtti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtti_step #(
  parameter int VALUE_BITS    = rtti_pkg::VALUE_BITS_DEF,
  parameter int POSITION_BITS = rtti_pkg::POSITION_BITS_DEF
) (
  input  wire logic [rtti_pkg::CH_W-1:0]    ch,
  input  wire logic                        start_req,
  input  wire logic [rtti_pkg::RADIX_W-1:0] radix,
  input  wire logic                        unsigned_mode,
  input  wire rtti_pkg::ctl_t              ctl,
  input  wire logic [VALUE_BITS-1:0]       acc,
  input  wire logic [POSITION_BITS-1:0]    pos,
  output rtti_pkg::ctl_t                   ctl_next,
  output logic [VALUE_BITS-1:0]            acc_next,
  output logic [POSITION_BITS-1:0]         pos_next,
  output logic [POSITION_BITS-1:0]         emit_pos,
  output logic                             emit
);

  localparam int PW = VALUE_BITS + rtti_pkg::RADIX_W;

  rtti_pkg::ctl_t                s;
  logic [VALUE_BITS-1:0]         a;
  logic [POSITION_BITS-1:0]      p;
  logic [VALUE_BITS-1:0]         lim;
  logic [rtti_pkg::RADIX_W-1:0]  b_eff;
  logic [rtti_pkg::DIGIT_W-1:0]  d;
  logic                          is_digit;
  logic [PW-1:0]                 prod;
  logic                          prod_over;
  logic                          bad_radix;
  logic                          zero_lead;
  logic                          do_take;

  always_comb begin
    // state after a start beat, before this character is looked at
    s = ctl;
    a = acc;
    p = pos;
    bad_radix = (radix == rtti_pkg::RADIX_W'(1)) || (radix > rtti_pkg::BASE_MAX);
    if (start_req) begin
      s.negative   = 1'b0;
      s.overflowed = 1'b0;
      s.seen_digit = 1'b0;
      a            = '0;
      p            = '0;
      s.base       = bad_radix ? rtti_pkg::BASE_DETECT : radix;
      s.phase      = bad_radix ? rtti_pkg::PH_IDLE : rtti_pkg::PH_SPACE;
    end
  end

  // base used if this character is taken as a digit
  always_comb begin
    if (s.phase == rtti_pkg::PH_ZERO && s.base == rtti_pkg::BASE_DETECT) begin
      b_eff = rtti_pkg::BASE_OCT;
    end else if (s.base < rtti_pkg::RADIX_W'(2)) begin
      b_eff = rtti_pkg::BASE_DEC;
    end else begin
      b_eff = s.base;
    end
  end

  always_comb begin
    lim = '1;
    if (!unsigned_mode) begin
      lim = s.negative ? (VALUE_BITS'(1) << (VALUE_BITS - 1)) : ('1 >> 1);
    end
  end

  assign d         = rtti_pkg::digit_value(ch);
  assign is_digit  = d < {1'b0, b_eff};
  assign prod      = PW'(a) * PW'(b_eff) + PW'(d[rtti_pkg::RADIX_W-1:0]);
  assign prod_over = prod > PW'(lim);
  assign zero_lead = (s.base == rtti_pkg::BASE_DETECT || s.base == rtti_pkg::BASE_HEX)
                     && ch == rtti_pkg::CH_ZERO;

  always_comb begin
    ctl_next = s;
    acc_next = a;
    pos_next = p;
    emit_pos = p;
    emit     = 1'b0;
    do_take  = 1'b0;

    if (start_req && bad_radix) begin
      emit = 1'b1;
    end else if (s.phase != rtti_pkg::PH_IDLE) begin
      case (s.phase)
        rtti_pkg::PH_SPACE: begin
          if (rtti_pkg::is_space(ch)) begin
            ctl_next.phase = rtti_pkg::PH_SPACE;
          end else if (ch == rtti_pkg::CH_MINUS) begin
            ctl_next.negative = 1'b1;
            ctl_next.phase    = rtti_pkg::PH_SIGN;
          end else if (ch == rtti_pkg::CH_PLUS) begin
            ctl_next.phase = rtti_pkg::PH_SIGN;
          end else if (zero_lead) begin
            ctl_next.phase = rtti_pkg::PH_ZERO;
          end else begin
            do_take = 1'b1;
          end
        end
        rtti_pkg::PH_SIGN: begin
          if (zero_lead) ctl_next.phase = rtti_pkg::PH_ZERO;
          else do_take = 1'b1;
        end
        rtti_pkg::PH_ZERO: begin
          if (ch == rtti_pkg::CH_LC_X || ch == rtti_pkg::CH_UC_X) begin
            ctl_next.base  = rtti_pkg::BASE_HEX;
            ctl_next.phase = rtti_pkg::PH_PREFIX;
          end else begin
            // the leading zero counts as a digit
            ctl_next.seen_digit = 1'b1;
            do_take             = 1'b1;
          end
        end
        default: begin
          do_take = 1'b1;
        end
      endcase

      if (do_take) begin
        ctl_next.base = b_eff;
        if (!is_digit) begin
          emit           = 1'b1;
          ctl_next.phase = rtti_pkg::PH_IDLE;
        end else begin
          if (s.overflowed || prod_over) ctl_next.overflowed = 1'b1;
          else acc_next = prod[VALUE_BITS-1:0];
          ctl_next.seen_digit = 1'b1;
          ctl_next.phase      = rtti_pkg::PH_DIGITS;
        end
      end

      if (p != '1) pos_next = p + POSITION_BITS'(1);
    end
  end

endmodule

`default_nettype wire

@@ sv/rtti_emit.sv @@
// Result formatting: saturation, sign application and end offset clamp.
// Combinational; depends on rtti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtti_emit #(
  parameter int VALUE_BITS    = rtti_pkg::VALUE_BITS_DEF,
  parameter int POSITION_BITS = rtti_pkg::POSITION_BITS_DEF
) (
  input  wire logic                         unsigned_mode,
  input  wire rtti_pkg::ctl_t               ctl,
  input  wire logic [VALUE_BITS-1:0]        acc,
  input  wire logic [POSITION_BITS-1:0]     pos,
  output logic signed [rtti_pkg::VALUE_W-1:0] value,
  output logic                              range_error,
  output logic [rtti_pkg::END_W-1:0]         end_offset
);

  localparam int EW = (VALUE_BITS > rtti_pkg::VALUE_W) ? VALUE_BITS : rtti_pkg::VALUE_W;
  localparam int XW = (POSITION_BITS > rtti_pkg::END_W) ? POSITION_BITS : rtti_pkg::END_W;

  logic [VALUE_BITS-1:0] lim;
  logic [EW-1:0]         limx;
  logic [EW-1:0]         accx;
  logic [EW-1:0]         v;
  logic [XW-1:0]         posx;
  logic                  over;

  always_comb begin
    lim = '1;
    if (!unsigned_mode) begin
      lim = ctl.negative ? (VALUE_BITS'(1) << (VALUE_BITS - 1)) : ('1 >> 1);
    end
  end

  assign limx = EW'(lim);
  assign accx = EW'(acc);
  assign over = ctl.overflowed || (acc > lim);
  assign posx = XW'(pos);

  always_comb begin
    v           = '0;
    range_error = 1'b0;
    end_offset  = '0;
    if (ctl.seen_digit) begin
      end_offset = (posx > XW'({rtti_pkg::END_W{1'b1}})) ? '1 : posx[rtti_pkg::END_W-1:0];
      if (over) begin
        range_error = 1'b1;
        v = (!unsigned_mode && ctl.negative) ? (EW'(0) - limx) : limx;
      end else begin
        v = ctl.negative ? (EW'(0) - accx) : accx;
        // unsigned mode wraps a negated value to VALUE_BITS
        if (unsigned_mode) v = v & limx;
      end
    end
  end

  assign value = v[rtti_pkg::VALUE_W-1:0];

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking bench for radix_text_to_integer_core: streams characters, predicts each
// conversion in place and checks every result beat. Needs rtti_pkg, rtti_in_if, rtti_out_if.
`timescale 1ns / 1ps

module tb_top;
  import rtti_pkg::*;

  localparam int VB = VALUE_BITS_DEF;
  localparam logic [15:0] POS_MAX = 16'((1 << POSITION_BITS_DEF) - 1);
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_CHARS_PER_PHASE = 190;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               range_error;
    logic [END_W-1:0]   end_offset;
  } conv_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  rtti_in_if  din_if();
  rtti_out_if dout_if();

  radix_text_to_integer_core uut (
    .clk      (clk),
    .rst      (rst),
    .din      (din_if),
    .dout     (dout_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // parser state mirrored by the predictor
  bit           unsigned_mode = 1'b0;
  phase_t       parse_phase   = PH_IDLE;
  bit           neg_sign      = 1'b0;
  logic [5:0]   act_base      = '0;
  logic [63:0]  accum         = '0;
  bit           overflowed    = 1'b0;
  bit           seen_digit    = 1'b0;
  logic [15:0]  position      = '0;

  conv_result_t expected_convs[$];

  bit          src_idle = 1'b0;
  bit          snk_idle = 1'b0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sink_hold = 0;
  int unsigned stall_draw;

  function automatic bit is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_HT && c <= CH_CR);
  endfunction

  function automatic logic [6:0] char_digit(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return 7'(c - CH_ZERO);
    if (c >= CH_UC_A && c <= CH_UC_Z) return 7'(c - CH_UC_A + 10);
    if (c >= CH_LC_A && c <= CH_LC_Z) return 7'(c - CH_LC_A + 10);
    return NOT_DIGIT;
  endfunction

  function automatic logic [63:0] conv_limit();
    if (unsigned_mode) return (64'd1 << VB) - 64'd1;
    if (neg_sign) return 64'd1 << (VB - 1);
    return (64'd1 << (VB - 1)) - 64'd1;
  endfunction

  function automatic conv_result_t finish_conversion();
    conv_result_t r;
    logic [63:0] lim;
    logic [63:0] v;
    r = '0;
    v = '0;
    lim = conv_limit();
    if (seen_digit) begin
      r.end_offset = position;
      if (overflowed || accum > lim) begin
        r.range_error = 1'b1;
        v = unsigned_mode ? lim : (neg_sign ? 64'd0 - lim : lim);
      end else begin
        v = neg_sign ? 64'd0 - accum : accum;
        if (unsigned_mode) v &= lim;
      end
    end
    r.value = v[VALUE_W-1:0];
    parse_phase = PH_IDLE;
    return r;
  endfunction

  function automatic bit accumulate_digit(input logic [7:0] c, output conv_result_t res);
    logic [6:0]  d;
    logic [63:0] lim;
    logic [63:0] cutoff;
    logic [63:0] cutlim;
    res = '0;
    if (act_base < 2) act_base = BASE_DEC;
    d = char_digit(c);
    if (d >= act_base) begin
      res = finish_conversion();
      return 1'b1;
    end
    lim = conv_limit();
    cutoff = lim / act_base;
    cutlim = lim % act_base;
    // once saturated, digits are still consumed but no longer added
    if (overflowed || accum > cutoff || (accum == cutoff && d > cutlim))
      overflowed = 1'b1;
    else
      accum = accum * act_base + d;
    seen_digit = 1'b1;
    parse_phase = PH_DIGITS;
    return 1'b0;
  endfunction

  function automatic bit first_digit(input logic [7:0] c, output conv_result_t res);
    res = '0;
    if ((act_base == BASE_DETECT || act_base == BASE_HEX) && c == CH_ZERO) begin
      parse_phase = PH_ZERO;
      return 1'b0;
    end
    if (act_base == BASE_DETECT) act_base = BASE_DEC;
    return accumulate_digit(c, res);
  endfunction

  function automatic bit parse_char(input logic [7:0] c, input logic st, input logic [5:0] rdx,
                                    output conv_result_t res);
    bit done;
    done = 1'b0;
    res = '0;
    if (st) begin
      neg_sign = 1'b0;
      accum = '0;
      overflowed = 1'b0;
      seen_digit = 1'b0;
      position = '0;
      if (rdx == 6'd1 || rdx > BASE_MAX) begin
        act_base = BASE_DETECT;
        res = finish_conversion();
        return 1'b1;
      end
      act_base = rdx;
      parse_phase = PH_SPACE;
    end
    if (parse_phase == PH_IDLE) return 1'b0;
    case (parse_phase)
      PH_SPACE: begin
        if (!is_blank(c)) begin
          if (c == CH_MINUS) begin
            neg_sign = 1'b1;
            parse_phase = PH_SIGN;
          end else if (c == CH_PLUS) begin
            parse_phase = PH_SIGN;
          end else begin
            done = first_digit(c, res);
          end
        end
      end
      PH_SIGN: done = first_digit(c, res);
      PH_ZERO: begin
        if (c == CH_LC_X || c == CH_UC_X) begin
          act_base = BASE_HEX;
          parse_phase = PH_PREFIX;
        end else begin
          // the leading zero itself counts as a digit
          if (act_base == BASE_DETECT) act_base = BASE_OCT;
          seen_digit = 1'b1;
          accum = '0;
          parse_phase = PH_DIGITS;
          done = accumulate_digit(c, res);
        end
      end
      default: done = accumulate_digit(c, res);
    endcase
    if (position < POS_MAX) position++;
    return done;
  endfunction

  // predict on every accepted character beat, check every result beat
  always @(posedge clk) begin
    conv_result_t got_res;
    conv_result_t want;
    if (!rst) begin
      if (din_if.valid && din_if.ready)
        if (parse_char(din_if.ch, din_if.start_req, din_if.radix, got_res))
          expected_convs.push_back(got_res);
      if (cfg_we) unsigned_mode = cfg_wdata;
      if (dout_if.valid && dout_if.ready) begin
        n_checked++;
        if (expected_convs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected result beat: value=%h range_error=%b end=%0d", $time,
                     dout_if.value, dout_if.range_error, dout_if.end_offset);
        end else begin
          want = expected_convs.pop_front();
          if (dout_if.value !== want.value || dout_if.range_error !== want.range_error ||
              dout_if.end_offset !== want.end_offset) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] mismatch: exp value=%h rerr=%b end=%0d, got value=%h rerr=%b end=%0d",
                       $time, want.value, want.range_error, want.end_offset,
                       dout_if.value, dout_if.range_error, dout_if.end_offset);
          end
        end
      end
    end
  end

  // result sink: random stall after each taken beat while snk_idle is set
  always @(posedge clk) begin
    if (rst) begin
      dout_if.ready <= 1'b0;
      sink_hold <= 0;
    end else if (dout_if.valid && dout_if.ready) begin
      stall_draw = snk_idle ? $urandom_range(0, 7) : 0;
      sink_hold <= stall_draw;
      dout_if.ready <= (stall_draw == 0);
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      dout_if.ready <= (sink_hold == 1);
    end else begin
      dout_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d conversions outstanding", cycle_count,
               expected_convs.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // valid stays high across back-to-back beats; it only drops for a drawn gap
  task automatic send_char(input logic [7:0] c, input logic st, input logic [5:0] rdx);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      din_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_if.valid     <= 1'b1;
    din_if.ch        <= c;
    din_if.start_req <= st;
    din_if.radix     <= rdx;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_text(input string s, input logic [5:0] rdx, input bit add_nul);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], i == 0, i == 0 ? rdx : 6'($urandom_range(0, 63)));
    if (add_nul) send_char(8'h00, 1'b0, rdx);
  endtask

  task automatic wait_drained();
    din_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_convs.size() != 0) @(posedge clk);
    // characters with no result may still sit in the pipeline
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_mode(input bit m);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return 8'(CH_ZERO + d);
    return 8'(($urandom_range(0, 1) ? CH_UC_A : CH_LC_A) + d - 10);
  endfunction

  function automatic logic [7:0] blank_char();
    if ($urandom_range(0, 2) == 0) return CH_SPACE;
    return 8'($urandom_range(CH_HT, CH_CR));
  endfunction

  task test_directed_bases();
    src_idle = 1'b1;
    snk_idle = 1'b1;
    send_text(" \t\n-123", BASE_DEC, 1'b1);
    send_text("+0x1Fz", BASE_DETECT, 1'b0);
    send_text("0X7fffFFFF", BASE_HEX, 1'b1);
    send_text("07779", BASE_DETECT, 1'b0);
    send_text("101012", 6'd2, 1'b0);
    send_text("zZ", BASE_MAX, 1'b1);
    send_text("19a", 6'd9, 1'b1);
    send_text("0", BASE_DETECT, 1'b1);
  endtask

  task test_special_cases();
    src_idle = 1'b0;
    snk_idle = 1'b1;
    // idle stream: no start, nothing open
    send_char("7", 1'b0, BASE_DEC);
    send_char(8'hFF, 1'b0, 6'h3F);
    // restart mid-string drops the first conversion
    send_text("12", BASE_DEC, 1'b0);
    send_text("-34", BASE_DEC, 1'b1);
    // invalid bases finish on the start beat
    send_text("5", 6'd1, 1'b0);
    send_text("5", 6'd37, 1'b0);
    send_text("5", 6'd63, 1'b0);
    // no digits taken
    send_text("0xg", BASE_DETECT, 1'b0);
    send_text("-", BASE_DEC, 1'b1);
    send_char(8'h00, 1'b1, BASE_DEC);
    // overflow and the signed limits
    send_text("99999999999", BASE_DEC, 1'b1);
    send_text("-99999999999", BASE_DEC, 1'b1);
    send_text("2147483648", BASE_DEC, 1'b1);
    send_text("-2147483648", BASE_DEC, 1'b1);
    send_text("-2147483649", BASE_DEC, 1'b1);
    send_text("0x100000000", BASE_DETECT, 1'b1);
  endtask

  task test_unsigned_mode();
    apply_mode(1'b1);
    src_idle = 1'b1;
    snk_idle = 1'b0;
    send_text("4294967295", BASE_DEC, 1'b1);
    send_text("4294967296", BASE_DEC, 1'b1);
    send_text("-1", BASE_DEC, 1'b1);
    send_text("-4294967295", BASE_DEC, 1'b1);
    send_text("-4294967296", BASE_DEC, 1'b1);
    send_text("+0xFFFFFFFF", BASE_DETECT, 1'b1);
    apply_mode(1'b0);
  endtask

  task test_long_string();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    // a long run of leading blanks before the digits arrive
    for (int i = 0; i < 100; i++) send_char(CH_SPACE, i == 0, BASE_DEC);
    send_char("4", 1'b0, BASE_DEC);
    send_char("2", 1'b0, BASE_DEC);
    send_char(8'h00, 1'b0, BASE_DEC);
  endtask

  task automatic send_random_string();
    logic [7:0] s[$];
    logic [5:0] rdx;
    int         sel;
    int         base_eff;
    int         ndig;
    sel = $urandom_range(0, 19);
    if (sel == 0)      rdx = $urandom_range(0, 1) ? 6'd1 : 6'($urandom_range(37, 63));
    else if (sel < 6)  rdx = BASE_DETECT;
    else if (sel < 9)  rdx = BASE_HEX;
    else if (sel < 12) rdx = BASE_DEC;
    else if (sel < 14) rdx = BASE_OCT;
    else               rdx = 6'($urandom_range(2, 36));
    base_eff = (rdx < 2 || rdx > BASE_MAX) ? 10 : rdx;

    // stray character ahead of the string
    if ($urandom_range(0, 7) == 0) send_char(8'($urandom_range(0, 255)), 1'b0,
                                             6'($urandom_range(0, 63)));

    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) s.push_back(blank_char());
    case ($urandom_range(0, 3))
      0: s.push_back(CH_MINUS);
      1: s.push_back(CH_PLUS);
      default: ;
    endcase
    if (rdx == BASE_DETECT || rdx == BASE_HEX) begin
      case ($urandom_range(0, 3))
        0: begin
          s.push_back(CH_ZERO);
          if (rdx == BASE_DETECT) base_eff = 8;
        end
        1: begin
          s.push_back(CH_ZERO);
          s.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
          base_eff = 16;
        end
        default: ;
      endcase
    end
    ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 8);
    repeat (ndig) s.push_back(digit_char($urandom_range(0, base_eff - 1)));
    case ($urandom_range(0, 4))
      1: s.push_back(8'($urandom_range(0, 255)));
      2: s.push_back(base_eff < 36 ? digit_char($urandom_range(base_eff, 35)) : CH_PLUS);
      3: ;  // left open, the next start abandons it
      default: s.push_back(8'h00);
    endcase
    if (s.size() == 0) s.push_back(8'($urandom_range(0, 255)));

    foreach (s[i]) send_char(s[i], i == 0, i == 0 ? rdx : 6'($urandom_range(0, 63)));
  endtask

  task test_random_strings();
    int unsigned mark;
    for (int p = 0; p < 5; p++) begin
      apply_mode(p % 2);
      src_idle = (p != 2);
      snk_idle = (p != 3);
      mark = n_sent;
      while (n_sent - mark < RAND_CHARS_PER_PHASE) send_random_string();
      // close whatever is still open before the next mode write
      send_char(8'h00, 1'b0, BASE_DETECT);
    end
  endtask

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= 1'b0;
    din_if.valid     <= 1'b0;
    din_if.ch        <= '0;
    din_if.start_req <= 1'b0;
    din_if.radix     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed_bases();
    test_special_cases();
    test_unsigned_mode();
    test_long_string();
    test_random_strings();

    apply_mode(1'b0);
    wait_drained();
    repeat (8) @(posedge clk);
    fail_count += expected_convs.size();

    $display("Sent %0d characters and checked %0d conversion results", n_sent, n_checked);
    $display("Covered fixed and detected bases, signs, overflow, both modes, long strings");
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ radix_text_to_integer_core.f @@
sv/rtti_pkg.sv
sv/rtti_in_if.sv
sv/rtti_out_if.sv
sv/rtti_step.sv
sv/rtti_emit.sv
sv/radix_text_to_integer_core.sv
verif/tb_top.sv
